// ----- hdl/csl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package csl_pkg;

  localparam int unsigned MAX_N         = 256;
  localparam int unsigned FRACTION_BITS = 24;
  localparam int unsigned TABLE_DEPTH   = 97;
  localparam int unsigned TBL_AW        = $clog2(TABLE_DEPTH);

  localparam int unsigned IDX_CAP_I = ((MAX_N - 1) > 255) ? 255 : (MAX_N - 1);
  localparam logic [7:0]  IDX_CAP   = 8'(IDX_CAP_I);

  // generator moduli, multipliers and increments
  localparam logic [35:0] GM1 = 36'd259200;
  localparam logic [17:0] GA1 = 18'd7141;
  localparam logic [17:0] GC1 = 18'd54773;
  localparam logic [35:0] GM2 = 36'd134456;
  localparam logic [17:0] GA2 = 18'd8121;
  localparam logic [17:0] GC2 = 18'd28411;
  localparam logic [35:0] GM3 = 36'd243000;
  localparam logic [17:0] GA3 = 18'd4561;
  localparam logic [17:0] GC3 = 18'd51349;
  localparam logic [17:0] SLOT_MUL = 18'(TABLE_DEPTH);
  localparam logic [35:0] DEN_FIX  = GM1 * GM2;

  // reciprocals: floor(2^31 / m) for the moduli, floor(2^60 / DEN_FIX) for the
  // fixed-point conversion; the quotient estimate is short by at most one
  localparam logic [24:0] RCP_M1  = 25'((64'd1 << 31) / 64'd259200);
  localparam logic [24:0] RCP_M2  = 25'((64'd1 << 31) / 64'd134456);
  localparam logic [24:0] RCP_M3  = 25'((64'd1 << 31) / 64'd243000);
  localparam logic [24:0] RCP_FIX = 25'((64'd1 << 60) / (64'd259200 * 64'd134456));

  // generator values right before the table fill for seed 1
  localparam longint unsigned SEED_A = (64'd7141 * 64'd54772 + 64'd54773) % 64'd259200;
  localparam longint unsigned SEED_B = (64'd7141 * SEED_A + 64'd54773) % 64'd259200;
  localparam logic [17:0] SEED_G1 = 18'(SEED_B);
  localparam logic [17:0] SEED_G2 = 18'(SEED_A % 64'd134456);
  localparam logic [17:0] SEED_G3 = 18'(SEED_B % 64'd243000);

  // reduction sequence, counted down
  localparam logic [2:0] RED_STEPS   = 3'd4;
  localparam logic [2:0] STEP_ACC_HI = 3'd4;
  localparam logic [2:0] STEP_T_LO   = 3'd3;
  localparam logic [2:0] STEP_T_HI   = 3'd2;
  localparam logic [2:0] STEP_FIN    = 3'd1;

  typedef enum logic [2:0] {
    OP_G1   = 3'd0,
    OP_G2   = 3'd1,
    OP_G3   = 3'd2,
    OP_SLOT = 3'd3,
    OP_FIX  = 3'd4
  } op_t;

  typedef struct packed {
    logic              load_in;
    logic              run_start;
    logic              seed_init;
    logic              mul_en;
    logic              div_load;
    logic              div_step;
    logic              wb_en;
    op_t               op;
    logic              ram_we;
    logic              ram_re;
    logic              ram_sel_seed;
    logic [TBL_AW-1:0] seed_idx;
    logic              cap_target;
    logic              acc_en;
    logic              out_load;
  } csl_cmd_t;

  typedef struct packed {
    logic div_last;
    logic item_last;
    logic out_busy;
  } csl_sts_t;

endpackage
`default_nettype wire

// ----- hdl/categorical_sampler_shuffled_lcg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Categorical sampler, inverse-CDF over a stream of Q1.24 probabilities.
// Input channel: one word per category, prob in in_tdata, in_tlast marks the
// final category of a run. Output channel: one word per run, the chosen
// category index in out_tdata and the reached flag in out_tuser (0 means the
// running sum never met the target and the last index was taken).
// A word inside a run is accepted, then accumulated, before the next word is
// taken; the last word of a run also loads the output register. The first word
// of a run draws a target first: four generator/slot steps (multiply, load,
// reciprocal reduction, write back), a table read and a fixed-point conversion.
// The first draw after reset also fills the 97-entry shuffle table.
// Reset clears the generators and all control state; the table is refilled by
// that first draw. The output register parts the channels: new words are taken
// while a result waits; if out_tready stays low, the next result holds in its
// final step and input stops until the waiting word is taken.
module categorical_sampler_shuffled_lcg_core
  import csl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [24:0] prob
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [7:0] choice
  output logic             out_tuser   // [0] reached
);

  csl_cmd_t cmd;
  csl_sts_t sts;

  // sequencer: seeding, draw, accumulate, emit
  csl_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_tvalid),
    .in_ready(in_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // generators, reciprocal reducer, shuffle table, accumulator, output register
  csl_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_prob    (in_tdata[24:0]),
    .in_last    (in_tlast),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_choice (out_tdata),
    .out_reached(out_tuser)
  );

endmodule
`default_nettype wire

// ----- hdl/csl_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module csl_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 97
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/csl_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module csl_dp
  import csl_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire csl_cmd_t cmd,
  output csl_sts_t      sts,
  input  wire logic [24:0] in_prob,
  input  wire logic     in_last,
  input  wire logic     out_ready,
  output logic          out_valid,
  output logic [7:0]    out_choice,
  output logic          out_reached
);

  logic [17:0] g1_r, g2_r, g3_r;
  logic [35:0] mul_r;
  logic [60:0] acc_r;
  logic [36:0] t_r;
  logic [35:0] rem_r;
  logic [23:0] q_r;
  logic [2:0]  cnt_r;
  logic [TBL_AW-1:0] slot_r;
  logic [23:0] target_r;
  logic [32:0] sum_r;
  logic [7:0]  eidx_r, chosen_r;
  logic        found_r;
  logic [24:0] prob_r;
  logic        last_r;
  logic        out_valid_r;
  logic [7:0]  out_choice_r;
  logic        out_reached_r;

  logic [17:0] mul_a, mul_b, mul_c;
  logic [35:0] mul_nxt;
  logic [35:0] den;
  logic [24:0] rcp;
  logic        is_fix;
  logic [24:0] qe;
  logic [17:0] mop_a;
  logic [24:0] mop_b;
  logic [42:0] mprod;
  logic [36:0] num;
  logic [36:0] r0;
  logic        ge;
  logic [36:0] r1;
  logic [TBL_AW-1:0] ram_addr;
  logic [23:0] ram_rdata;
  logic [33:0] sum_ext;
  logic [32:0] sum_nxt;
  logic        hit;

  always_comb begin
    mul_a = g1_r;
    mul_b = GA1;
    mul_c = GC1;
    den   = GM1;
    rcp   = RCP_M1;
    case (cmd.op)
      OP_G1: begin
        mul_a = g1_r; mul_b = GA1; mul_c = GC1; den = GM1; rcp = RCP_M1;
      end
      OP_G2: begin
        mul_a = g2_r; mul_b = GA2; mul_c = GC2; den = GM2; rcp = RCP_M2;
      end
      OP_G3: begin
        mul_a = g3_r; mul_b = GA3; mul_c = GC3; den = GM3; rcp = RCP_M3;
      end
      OP_SLOT: begin
        mul_a = g3_r; mul_b = SLOT_MUL; mul_c = 18'd0; den = GM3; rcp = RCP_M3;
      end
      OP_FIX: begin
        mul_a = g1_r; mul_b = GM2[17:0]; mul_c = g2_r; den = DEN_FIX; rcp = RCP_FIX;
      end
      default: begin
        mul_a = g1_r; mul_b = GA1; mul_c = GC1; den = GM1; rcp = RCP_M1;
      end
    endcase
  end

  assign mul_nxt = ({18'd0, mul_a} * {18'd0, mul_b}) + {18'd0, mul_c};

  // reciprocal reduction: estimate the quotient from x * rcp, then fix it up
  // with one compare and subtract against the modulus
  assign is_fix = (cmd.op == OP_FIX);
  assign qe     = is_fix ? acc_r[60:36] : acc_r[55:31];

  always_comb begin
    mop_a = mul_r[17:0];
    mop_b = rcp;
    if (!cmd.div_load) begin
      case (cnt_r)
        STEP_ACC_HI: begin
          mop_a = mul_r[35:18]; mop_b = rcp;
        end
        STEP_T_LO: begin
          mop_a = den[17:0]; mop_b = qe;
        end
        STEP_T_HI: begin
          mop_a = den[35:18]; mop_b = qe;
        end
        default: begin
          mop_a = mul_r[17:0]; mop_b = rcp;
        end
      endcase
    end
  end

  assign mprod = {25'd0, mop_a} * {18'd0, mop_b};
  // the remainder is below twice the modulus, so 37 bits are enough
  assign num   = is_fix ? {mul_r[12:0], 24'd0} : {1'b0, mul_r};
  assign r0    = num - t_r;
  assign ge    = r0 >= {1'b0, den};
  assign r1    = ge ? (r0 - {1'b0, den}) : r0;

  // saturating accumulate and compare
  assign sum_ext = {1'b0, sum_r} + {9'd0, prob_r};
  assign sum_nxt = sum_ext[33] ? {33{1'b1}} : sum_ext[32:0];
  assign hit     = !found_r && (sum_nxt >= {9'd0, target_r});

  assign ram_addr = cmd.ram_sel_seed ? cmd.seed_idx : slot_r;

  csl_ram #(
    .WIDTH(24),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (cmd.ram_we),
    .waddr(ram_addr),
    .wdata(q_r),
    .re   (cmd.ram_re),
    .raddr(ram_addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g1_r     <= '0;
      g2_r     <= '0;
      g3_r     <= '0;
      cnt_r    <= '0;
      target_r <= '0;
      sum_r    <= '0;
      eidx_r   <= '0;
      chosen_r <= '0;
      found_r  <= 1'b0;
    end else begin
      if (cmd.seed_init) begin
        g1_r <= SEED_G1;
        g2_r <= SEED_G2;
        g3_r <= SEED_G3;
      end
      if (cmd.div_load) begin
        cnt_r <= RED_STEPS;
      end else if (cmd.div_step) begin
        cnt_r <= cnt_r - 3'd1;
      end
      if (cmd.wb_en) begin
        case (cmd.op)
          OP_G1:   g1_r <= rem_r[17:0];
          OP_G2:   g2_r <= rem_r[17:0];
          OP_G3:   g3_r <= rem_r[17:0];
          default: ;
        endcase
      end
      if (cmd.cap_target) begin
        target_r <= ram_rdata;
      end
      if (cmd.run_start) begin
        sum_r    <= '0;
        eidx_r   <= '0;
        chosen_r <= '0;
        found_r  <= 1'b0;
      end else if (cmd.acc_en) begin
        sum_r <= sum_nxt;
        if (hit) begin
          found_r  <= 1'b1;
          chosen_r <= eidx_r;
        end
        if (!last_r && (eidx_r < IDX_CAP)) begin
          eidx_r <= eidx_r + 8'd1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      prob_r <= in_prob;
      last_r <= in_last;
    end
    if (cmd.mul_en) begin
      mul_r <= mul_nxt;
    end
    if (cmd.div_load) begin
      acc_r <= {18'd0, mprod};
    end else if (cmd.div_step) begin
      case (cnt_r)
        STEP_ACC_HI: acc_r <= acc_r + {mprod, 18'd0};
        STEP_T_LO:   t_r   <= mprod[36:0];
        STEP_T_HI:   t_r   <= t_r + {mprod[18:0], 18'd0};
        STEP_FIN: begin
          rem_r <= r1[35:0];
          q_r   <= qe[23:0] + {23'd0, ge};
        end
        default: ;
      endcase
    end
    if (cmd.wb_en && (cmd.op == OP_SLOT)) begin
      slot_r <= q_r[TBL_AW-1:0];
    end
    if (cmd.out_load) begin
      out_choice_r  <= found_r ? chosen_r : eidx_r;
      out_reached_r <= found_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.div_last  = (cnt_r == STEP_FIN);
  assign sts.item_last = last_r;
  assign sts.out_busy  = out_valid_r && !out_ready;

  assign out_valid   = out_valid_r;
  assign out_choice  = out_choice_r;
  assign out_reached = out_reached_r;

endmodule
`default_nettype wire

// ----- hdl/csl_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module csl_ctrl
  import csl_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire csl_sts_t sts,
  output csl_cmd_t      cmd
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MUL  = 9'b000000010,
    S_DLD  = 9'b000000100,
    S_DIV  = 9'b000001000,
    S_WB   = 9'b000010000,
    S_RD   = 9'b000100000,
    S_CAP  = 9'b001000000,
    S_ACC  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic              seed_mode_r, seed_mode_nxt;
  logic              seeded_r, seeded_nxt;
  logic              in_run_r, in_run_nxt;
  logic [TBL_AW-1:0] k_r, k_nxt;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    seed_mode_nxt = seed_mode_r;
    seeded_nxt    = seeded_r;
    in_run_nxt    = in_run_r;
    k_nxt         = k_r;
    cmd           = '0;
    cmd.op        = op_r;
    cmd.seed_idx  = k_r;
    in_ready      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          if (in_run_r) begin
            state_nxt = S_ACC;
          end else begin
            cmd.run_start = 1'b1;
            op_nxt        = OP_G1;
            state_nxt     = S_MUL;
            if (!seeded_r) begin
              cmd.seed_init = 1'b1;
              seed_mode_nxt = 1'b1;
              k_nxt         = '0;
            end
          end
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_DLD;
      end
      S_DLD: begin
        cmd.div_load = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        cmd.wb_en = 1'b1;
        state_nxt = S_MUL;
        case (op_r)
          OP_G1:   op_nxt = OP_G2;
          OP_G2:   op_nxt = seed_mode_r ? OP_FIX : OP_G3;
          OP_G3:   op_nxt = OP_SLOT;
          OP_SLOT: state_nxt = S_RD;
          OP_FIX: begin
            cmd.ram_we       = 1'b1;
            cmd.ram_sel_seed = seed_mode_r;
            op_nxt           = OP_G1;
            if (!seed_mode_r) begin
              state_nxt = S_ACC;
            end else if (k_r == TBL_AW'(TABLE_DEPTH - 1)) begin
              // table full: go on with the first draw
              seed_mode_nxt = 1'b0;
              seeded_nxt    = 1'b1;
            end else begin
              k_nxt = k_r + 1'b1;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_RD: begin
        cmd.ram_re = 1'b1;
        state_nxt  = S_CAP;
      end
      S_CAP: begin
        cmd.cap_target = 1'b1;
        op_nxt         = OP_FIX;
        state_nxt      = S_MUL;
      end
      S_ACC: begin
        cmd.acc_en = 1'b1;
        in_run_nxt = !sts.item_last;
        state_nxt  = sts.item_last ? S_OUT : S_IDLE;
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_G1;
      seed_mode_r <= 1'b0;
      seeded_r    <= 1'b0;
      in_run_r    <= 1'b0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      seed_mode_r <= seed_mode_nxt;
      seeded_r    <= seeded_nxt;
      in_run_r    <= in_run_nxt;
      k_r         <= k_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_div_to_wb: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) && sts.div_last |=> (state_r == S_WB))
    else $error("divider finished without write back");

  a_seeded_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(seeded_r))
    else $error("seeded flag dropped");

  a_ram_we_fix: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ram_we |-> (state_r == S_WB) && (op_r == OP_FIX))
    else $error("table written outside fixed-point write back");

  a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC) && sts.item_last |=> (state_r == S_OUT) && !in_run_r)
    else $error("last word did not lead to a result");
`endif

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import csl_pkg::*;

  typedef struct {
    logic [7:0] choice;
    logic       reached;
  } pick_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic [31:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tready = 1'b0;
  wire         in_tready;
  wire         out_tvalid;
  wire  [7:0]  out_tdata;
  wire         out_tuser;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  categorical_sampler_shuffled_lcg_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata),   // [24:0] prob
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), // [7:0] choice
    .out_tuser(out_tuser)  // [0] reached
  );

  // Sampler state mirror.
  longint unsigned g1, g2, g3, tgt, acc;
  longint unsigned shuf [TABLE_DEPTH];
  bit              is_seeded, mid_run, hit;
  int unsigned     pos, pick_pos;
  pick_t           picks_due [$];
  int              mismatches = 0;
  bit              stall_out = 1'b1;
  int unsigned     out_hold = 0;

  localparam longint unsigned SUM_SAT = (64'd1 << 33) - 1;

  function automatic longint unsigned q24(longint unsigned a, longint unsigned b);
    longint unsigned d, r, q;
    d = 64'd259200 * 64'd134456;
    r = (a * 64'd134456 + b) % d;
    q = 0;
    for (int k = 0; k < FRACTION_BITS; k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned next_target();
    longint unsigned slot, v;
    if (!is_seeded) begin
      g1 = (64'd7141 * 64'd54772 + 64'd54773) % 64'd259200;
      g2 = g1 % 64'd134456;
      g1 = (64'd7141 * g1 + 64'd54773) % 64'd259200;
      g3 = g1 % 64'd243000;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
        g1 = (64'd7141 * g1 + 64'd54773) % 64'd259200;
        g2 = (64'd8121 * g2 + 64'd28411) % 64'd134456;
        shuf[k] = q24(g1, g2);
      end
      is_seeded = 1'b1;
    end
    g1 = (64'd7141 * g1 + 64'd54773) % 64'd259200;
    g2 = (64'd8121 * g2 + 64'd28411) % 64'd134456;
    g3 = (64'd4561 * g3 + 64'd51349) % 64'd243000;
    slot = (TABLE_DEPTH * g3) / 64'd243000;
    if (slot >= TABLE_DEPTH) slot = TABLE_DEPTH - 1;
    v = shuf[slot];
    shuf[slot] = q24(g1, g2);
    return v;
  endfunction

  // Advance the mirror by one category word; queue a pick on the last one.
  task automatic predict_pick(input logic [24:0] p, input bit lst);
    pick_t e;
    if (!mid_run) begin
      tgt = next_target();
      acc = 0;
      pos = 0;
      pick_pos = 0;
      hit = 1'b0;
    end
    acc = acc + p;
    if (acc > SUM_SAT) acc = SUM_SAT;
    if (!hit && acc >= tgt) begin
      hit = 1'b1;
      pick_pos = pos;
    end
    if (lst) begin
      e.choice = hit ? pick_pos[7:0] : pos[7:0];
      e.reached = hit;
      picks_due.push_back(e);
      mid_run = 1'b0;
    end else begin
      mid_run = 1'b1;
      if (pos < IDX_CAP_I) pos++;
    end
  endtask

  task automatic report(input string what);
    mismatches++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  // Send one word after a random gap; hold it until taken. Drop valid only
  // when a gap follows, so each falling edge drives the bus once.
  task automatic send_word(input logic [24:0] p, input bit lst);
    int gap;
    gap = $urandom_range(0, 16);
    if ($urandom_range(0, 3) == 0) gap = 0;
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, p};
    in_tlast <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_pick(p, lst);
  endtask

  // Per word the receiver draws a pause; a stretch runs with no stalls.
  // Valid and ready both high at a falling edge means the word is taken at
  // the next rising edge.
  always @(negedge clk) begin
    if (out_tvalid && out_tready) begin
      out_hold <= stall_out ? $urandom_range(0, 16) : 0;
    end else if (out_hold != 0) begin
      out_tready <= 1'b0;
      out_hold <= out_hold - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Check each accepted pick against the oldest expectation.
  always @(posedge clk) begin
    pick_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (picks_due.size() == 0) begin
        report($sformatf("unexpected pick %0d", out_tdata));
      end else begin
        e = picks_due.pop_front();
        if (out_tdata !== e.choice)
          report($sformatf("choice %0d, want %0d", out_tdata, e.choice));
        if (out_tuser !== e.reached)
          report($sformatf("reached %0b, want %0b", out_tuser, e.reached));
      end
    end
  end

  function automatic logic [24:0] rand_prob();
    case ($urandom_range(0, 5))
      0: return 25'd0;
      1: return 25'h1000000;
      2: return 25'h1FFFFFF;
      3: return 25'($urandom_range(0, 1 << 16));
      default: return 25'($urandom_range(0, 25'h1000000));
    endcase
  endfunction

  // Release the input bus and wait for every expected pick.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (picks_due.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_word(25'd0, 1'b1);             // single-word run, zero weight
    send_word(25'h1000000, 1'b1);       // single-word run, full weight
    send_word(25'h1FFFFFF, 1'b1);       // all bits set
    send_word(25'd0, 1'b0);             // never reaches: fallback to last
    send_word(25'd0, 1'b0);
    send_word(25'd0, 1'b1);
    for (int k = 0; k < 3; k++) send_word(25'h1FFFFFF, 1'b0);
    send_word(25'h1FFFFFF, 1'b1);       // large sums
    send_word(25'h0555555, 1'b0);
    send_word(25'h0AAAAAA, 1'b0);
    send_word(25'h0555555, 1'b1);
    drain();
  endtask

  // Longer than the index cap: later words share the capped index.
  task automatic test_long_run();
    for (int k = 0; k < 300; k++) send_word(25'd0, k == 299);
    drain();
  endtask

  task automatic test_random();
    int n, len;
    n = 0;
    while (n < 480) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
      for (int k = 0; k < len; k++) begin
        send_word(($urandom_range(0, 1)) ? 25'($urandom_range(0, 1 << 23)) : rand_prob(),
                  k == len - 1);
        n++;
      end
      if ($urandom_range(0, 30) == 0) drain();  // hold off until all picks are in
      if (n > 200 && n < 280) stall_out = 1'b0;
      else stall_out = 1'b1;
    end
    drain();
  endtask

  initial begin
    #300000000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_long_run();
    test_random();
    repeat (400) @(posedge clk);
    if (mismatches == 0 && picks_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/csl_pkg.sv
hdl/csl_ram.sv
hdl/csl_dp.sv
hdl/csl_ctrl.sv
hdl/categorical_sampler_shuffled_lcg.sv
tb/tb.sv
